>>> hdl/integer_to_radix_digits_assert.svh
// Assertion macros shared by the block's modules.
// In synthesis builds they expand to nothing.
`ifndef INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define ITRD_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("itrd assertion failed");

// Check a property on every clock edge, including reset.
`define ITRD_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("itrd assertion failed");

`else

`define ITRD_ASSERT(name, clk, rst_n, prop)
`define ITRD_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

>>> hdl/itrd_pkg.sv
package itrd_pkg;

	// Default parameter values
	localparam int MAX_LEN_DEF     = 64;
	localparam int VALUE_WIDTH_DEF = 64;

	// Fixed field widths
	localparam int VALUE_IN_W = 64;
	localparam int RADIX_W    = 6;
	localparam int LEN_W      = 7;
	localparam int CHAR_W     = 7;
	localparam int POS_OUT_W  = 6;
	localparam int STATUS_W   = 2;

	// Valid radix range
	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

	// ASCII bases for the digit characters
	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_NUL     = 7'd0;
	localparam logic [CHAR_W-1:0] CHAR_A_MINUS = 7'd55;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_ZERO_LEN  = 2'd1,
		STAT_BAD_RADIX = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIRST,
		ST_DIV,
		ST_PUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic put_first;
		logic div_step;
		logic put_digit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic slot_free;
		logic first_last;
		logic div_done;
		logic digit_last;
	} sts_t;

	// Map a digit value 0..35 to its ASCII character
	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = CHAR_W'(d);
		if (d < 6'd10) begin
			return CHAR_ZERO + dx;
		end else begin
			return CHAR_A_MINUS + dx;
		end
	endfunction

endpackage

>>> hdl/itrd_ctrl.sv
`include "integer_to_radix_digits_assert.svh"

module itrd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  itrd_pkg::sts_t  sts,
	output logic            in_ready,
	output itrd_pkg::cmd_t  cmd
);
	import itrd_pkg::*;

	state_t state_q;
	state_t state_next;

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Pick the next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_FIRST;
				end
			end
			ST_FIRST: begin
				if (sts.slot_free) begin
					state_next = sts.first_last ? ST_IDLE : ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_next = ST_PUT;
				end
			end
			ST_PUT: begin
				if (sts.slot_free) begin
					state_next = sts.digit_last ? ST_IDLE : ST_DIV;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Drive the commands
	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_FIRST: begin
				cmd.put_first = sts.slot_free;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_PUT: begin
				cmd.put_digit = sts.slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	`ITRD_ASSERT(a_put_needs_slot, clk, arst_n, (cmd.put_first || cmd.put_digit) |-> sts.slot_free)
	`ITRD_ASSERT(a_done_goes_put, clk, arst_n, (state_q == ST_DIV && sts.div_done) |=> (state_q == ST_PUT))
	`ITRD_ASSERT(a_load_goes_first, clk, arst_n, cmd.load |=> (state_q == ST_FIRST && !in_ready))

endmodule

>>> hdl/itrd_dpath.sv
`include "integer_to_radix_digits_assert.svh"

module itrd_dpath #(
	parameter int MAX_LEN     = itrd_pkg::MAX_LEN_DEF,
	parameter int VALUE_WIDTH = itrd_pkg::VALUE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  itrd_pkg::cmd_t                    cmd,
	output itrd_pkg::sts_t                    sts,
	input  logic [itrd_pkg::VALUE_IN_W-1:0]   value,
	input  logic [itrd_pkg::RADIX_W-1:0]      radix,
	input  logic [itrd_pkg::LEN_W-1:0]        buf_len,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [itrd_pkg::CHAR_W-1:0]       char_code,
	output logic [itrd_pkg::POS_OUT_W-1:0]    position,
	output logic [itrd_pkg::STATUS_W-1:0]     status,
	output logic                              last
);
	import itrd_pkg::*;

	localparam int POS_W = $clog2(MAX_LEN);
	localparam int CNT_W = $clog2(VALUE_WIDTH);

	// Working registers
	logic [VALUE_WIDTH-1:0] val_q;
	logic [RADIX_W-1:0]     rem_q;
	logic [RADIX_W-1:0]     radix_q;
	logic [POS_W-1:0]       pos_q;
	logic [CNT_W-1:0]       bitcnt_q;
	status_t                err_q;

	// Output register
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      char_q;
	logic [POS_OUT_W-1:0]   pos_out_q;
	status_t                status_q;
	logic                   last_q;

	logic [LEN_W-1:0]       len_sat;
	status_t                err_next;
	logic [RADIX_W:0]       trial;
	logic [RADIX_W:0]       trial_sub;
	logic                   qbit;
	logic [RADIX_W-1:0]     rem_next;
	logic [POS_W-1:0]       pos_dec;

	// Classify the incoming word and clamp its length
	always_comb begin
		len_sat = (buf_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : buf_len;
		if (buf_len == '0) begin
			err_next = STAT_ZERO_LEN;
		end else if (radix < RADIX_MIN || radix > RADIX_MAX) begin
			err_next = STAT_BAD_RADIX;
		end else begin
			err_next = STAT_OK;
		end
	end

	// One restoring division step: shift in the dividend MSB, subtract if it fits
	always_comb begin
		trial     = {rem_q, val_q[VALUE_WIDTH-1]};
		trial_sub = trial - {1'b0, radix_q};
		qbit      = (trial >= {1'b0, radix_q});
		rem_next  = qbit ? trial_sub[RADIX_W-1:0] : trial[RADIX_W-1:0];
		pos_dec   = pos_q - POS_W'(1);
	end

	// Advance the working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q   <= value[VALUE_WIDTH-1:0];
			radix_q <= radix;
			pos_q   <= POS_W'(len_sat - LEN_W'(1));
			err_q   <= err_next;
		end
		if (cmd.div_step) begin
			val_q    <= {val_q[VALUE_WIDTH-2:0], qbit};
			rem_q    <= rem_next;
			bitcnt_q <= bitcnt_q + CNT_W'(1);
		end
		if (cmd.put_first || cmd.put_digit) begin
			rem_q    <= '0;
			bitcnt_q <= '0;
		end
		if (cmd.put_digit) begin
			pos_q <= pos_dec;
		end
	end

	// Hold the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put_first || cmd.put_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the output word
	always_ff @(posedge clk) begin
		if (cmd.put_first) begin
			char_q    <= CHAR_NUL;
			status_q  <= err_q;
			if (err_q != STAT_OK) begin
				pos_out_q <= '0;
				last_q    <= 1'b1;
			end else begin
				pos_out_q <= POS_OUT_W'(pos_q);
				last_q    <= (pos_q == '0);
			end
		end else if (cmd.put_digit) begin
			char_q    <= digit_char(rem_q);
			status_q  <= STAT_OK;
			pos_out_q <= POS_OUT_W'(pos_dec);
			last_q    <= (pos_dec == '0);
		end
	end

	// Report status to the controller
	always_comb begin
		sts.slot_free  = !out_valid_q || out_ready;
		sts.first_last = (err_q != STAT_OK) || (pos_q == '0);
		sts.div_done   = (bitcnt_q == CNT_W'(VALUE_WIDTH - 1));
		sts.digit_last = (pos_q == POS_W'(1));
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign position  = pos_out_q;
	assign status    = status_q;
	assign last      = last_q;

	`ITRD_ASSERT(a_rem_below_radix, clk, arst_n, cmd.div_step |-> (rem_q < radix_q))
	`ITRD_ASSERT(a_digit_pos_nonzero, clk, arst_n, cmd.put_digit |-> (pos_q != '0))
	`ITRD_ASSERT(a_error_word_shape, clk, arst_n, (out_valid_q && status_q != STAT_OK) |-> (pos_out_q == '0 && last_q && char_q == CHAR_NUL))
	`ITRD_ASSERT_ALWAYS(a_reset_no_word, clk, !arst_n |-> !out_valid_q)

endmodule

>>> hdl/integer_to_radix_digits.sv
// Channel  Signals                                      Words
// -------  -------------------------------------------  -----------------
// in       in_valid, in_ready, value, radix, buf_len    one word per item
// out      out_valid, out_ready, char_code, position,   1..MAX_LEN words
//          status, last                                 per item
//
// An error or a one-character buffer presents its single word once the output slot is free.
// Each digit is formed by the one-bit-per-cycle restoring divider, then loaded into the output register.
// One item is converted at a time; in_ready is high only while the converter is idle,
// which includes the time the last word of the previous item waits at the output.
// arst_n clears the controller and the output valid flag; no clearing pass is needed.
// out_ready low holds the word; the divider works on the next digit meanwhile.
module integer_to_radix_digits #(
	parameter int MAX_LEN     = itrd_pkg::MAX_LEN_DEF,
	parameter int VALUE_WIDTH = itrd_pkg::VALUE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [itrd_pkg::VALUE_IN_W-1:0]   value,
	input  logic [itrd_pkg::RADIX_W-1:0]      radix,
	input  logic [itrd_pkg::LEN_W-1:0]        buf_len,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [itrd_pkg::CHAR_W-1:0]       char_code,
	output logic [itrd_pkg::POS_OUT_W-1:0]    position,
	output logic [itrd_pkg::STATUS_W-1:0]     status,
	output logic                              last
);
	import itrd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	itrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	itrd_dpath #(
		.MAX_LEN     (MAX_LEN),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value),
		.radix     (radix),
		.buf_len   (buf_len),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.char_code (char_code),
		.position  (position),
		.status    (status),
		.last      (last)
	);

endmodule
